// File: rtl/dkmi_pkg.sv
// Package with shared constants, types and the base decoder of the k-mer indexer.
`timescale 1ns / 1ps
package dkmi_pkg;

	localparam int MAX_K = 8;
	localparam int K_W = 4;
	localparam int ADDR_W = 2 * MAX_K;
	localparam int SEEN_DEPTH = 1 << ADDR_W;
	localparam int IDX_W = 17;
	localparam int EPOCH_W = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

	localparam logic [7:0] CHAR_A_UC = 8'h41;
	localparam logic [7:0] CHAR_C_UC = 8'h43;
	localparam logic [7:0] CHAR_G_UC = 8'h47;
	localparam logic [7:0] CHAR_T_UC = 8'h54;
	localparam logic [7:0] CHAR_U_UC = 8'h55;
	localparam logic [7:0] CHAR_A_LC = 8'h61;
	localparam logic [7:0] CHAR_C_LC = 8'h63;
	localparam logic [7:0] CHAR_G_LC = 8'h67;
	localparam logic [7:0] CHAR_T_LC = 8'h74;
	localparam logic [7:0] CHAR_U_LC = 8'h75;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} seen_state_t;

	typedef struct packed {
		logic              valid;
		logic              start;
		logic              cand;
		logic              sent;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0]  index;
	} lookup_t;

	typedef struct packed {
		logic             push;
		logic [IDX_W-1:0] index;
	} result_t;

	// Returns {invalid, code}; an invalid character gives code zero.
	function automatic logic [2:0] decode_base(input logic [7:0] ch);
		logic [2:0] r;
		case (ch)
			CHAR_A_UC, CHAR_A_LC: r = {1'b0, CODE_A};
			CHAR_C_UC, CHAR_C_LC: r = {1'b0, CODE_C};
			CHAR_G_UC, CHAR_G_LC: r = {1'b0, CODE_G};
			CHAR_T_UC, CHAR_T_LC, CHAR_U_UC, CHAR_U_LC: r = {1'b0, CODE_T};
			default: r = {1'b1, CODE_A};
		endcase
		return r;
	endfunction

endpackage

// File: rtl/dkmi_window.sv
// Base window, fill count and k register; forms the lookup for each character.
`timescale 1ns / 1ps
module dkmi_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [dkmi_pkg::K_W-1:0] cfg_wdata,
	input  logic                  accept,
	input  logic [7:0]            base_char,
	input  logic                  seq_start,
	output dkmi_pkg::lookup_t     lookup
);
	import dkmi_pkg::*;

	logic [K_W-1:0]    kmer_q;
	logic [ADDR_W-1:0] win_codes_q;
	logic [MAX_K-1:0]  win_bad_q;
	logic [K_W-1:0]    fill_q;

	logic [K_W-1:0]    k_act;
	logic [K_W-1:0]    k_m1;
	logic [K_W:0]      code_sh;
	logic [2:0]        dec;
	logic [ADDR_W-1:0] base_codes;
	logic [MAX_K-1:0]  base_bad;
	logic [K_W-1:0]    fill_base;
	logic [ADDR_W-1:0] codes_next;
	logic [MAX_K-1:0]  bad_next;
	logic [K_W-1:0]    fill_next;

	always_comb begin
		if (kmer_q == '0) begin
			k_act = K_W'(1);
		end else if (kmer_q > K_W'(MAX_K)) begin
			k_act = K_W'(MAX_K);
		end else begin
			k_act = kmer_q;
		end
		k_m1 = k_act - K_W'(1);
		code_sh = {k_m1, 1'b0};
		dec = decode_base(base_char);
		base_codes = seq_start ? '0 : win_codes_q;
		base_bad = seq_start ? '0 : win_bad_q;
		fill_base = seq_start ? '0 : fill_q;
		codes_next = (base_codes >> 2) | (ADDR_W'(dec[1:0]) << code_sh);
		bad_next = (base_bad >> 1) | (MAX_K'(dec[2]) << k_m1);
		fill_next = (fill_base < k_act) ? fill_base + K_W'(1) : fill_base;
		lookup.valid = accept;
		lookup.start = seq_start;
		lookup.cand = (fill_next == k_act);
		lookup.sent = |bad_next;
		lookup.addr = codes_next;
		lookup.index = lookup.sent ? (IDX_W'(1) << {k_act, 1'b0}) : IDX_W'(codes_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q <= K_W'(MAX_K);
			win_codes_q <= '0;
			win_bad_q <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			kmer_q <= cfg_wdata;
			win_codes_q <= '0;
			win_bad_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			win_codes_q <= codes_next;
			win_bad_q <= bad_next;
			fill_q <= fill_next;
		end
	end

endmodule

// File: rtl/dkmi_seen.sv
// Seen-set memory with epoch tags, read-modify-write forwarding and clearing pass.
`timescale 1ns / 1ps
module dkmi_seen (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              in_valid,
	input  logic              seq_start,
	input  dkmi_pkg::lookup_t lookup,
	output logic              lookup_ready,
	output dkmi_pkg::result_t result
);
	import dkmi_pkg::*;

	logic [EPOCH_W-1:0] seen_mem [SEEN_DEPTH];

	seen_state_t        state_q;
	seen_state_t        state_next;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [EPOCH_W-1:0] sent_tag_q;
	logic               wr_valid_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [EPOCH_W-1:0] wr_tag_q;

	logic               valid_s1;
	logic               cand_s1;
	logic               sent_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [IDX_W-1:0]   index_s1;
	logic [EPOCH_W-1:0] epoch_s1;
	logic [EPOCH_W-1:0] rd_tag;

	logic               at_last;
	logic               wrap_now;
	logic               clr_active;
	logic [EPOCH_W-1:0] item_epoch;
	logic               seen_hit;
	logic               is_new;
	logic               upd_we;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [EPOCH_W-1:0] mem_wdata;

	assign at_last = (epoch_q == EPOCH_LAST);
	assign wrap_now = (cfg_we && at_last) || (in_valid && seq_start && at_last && !valid_s1);
	assign item_epoch = lookup.start ? epoch_q + EPOCH_W'(1) : epoch_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (wrap_now) begin
					state_next = ST_CLEAR;
				end
			end
			default: state_next = ST_CLEAR;
		endcase
	end

	always_comb begin
		clr_active = 1'b0;
		lookup_ready = 1'b0;
		case (state_q)
			ST_CLEAR: clr_active = 1'b1;
			ST_RUN: lookup_ready = !(seq_start && at_last);
			default: clr_active = 1'b1;
		endcase
	end

	always_comb begin
		if (sent_s1) begin
			seen_hit = (sent_tag_q == epoch_s1);
		end else begin
			seen_hit = (rd_tag == epoch_s1) ||
				(wr_valid_q && (wr_addr_q == addr_s1) && (wr_tag_q == epoch_s1));
		end
		is_new = valid_s1 && cand_s1 && !seen_hit;
		upd_we = is_new && !sent_s1;
		mem_we = clr_active || upd_we;
		mem_waddr = clr_active ? clr_addr_q : addr_s1;
		mem_wdata = clr_active ? EPOCH_CLEAR : epoch_s1;
		result.push = is_new;
		result.index = index_s1;
	end

	always_ff @(posedge clk) begin
		rd_tag <= seen_mem[lookup.addr];
		if (mem_we) begin
			seen_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup.valid) begin
			cand_s1 <= lookup.cand;
			sent_s1 <= lookup.sent;
			addr_s1 <= lookup.addr;
			index_s1 <= lookup.index;
			epoch_s1 <= item_epoch;
		end
		wr_addr_q <= addr_s1;
		wr_tag_q <= epoch_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			epoch_q <= EPOCH_FIRST;
			sent_tag_q <= EPOCH_CLEAR;
			wr_valid_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_next;
			valid_s1 <= lookup.valid;
			wr_valid_q <= upd_we;
			if (clr_active) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				epoch_q <= EPOCH_FIRST;
				sent_tag_q <= EPOCH_CLEAR;
			end else begin
				clr_addr_q <= '0;
				if (wrap_now) begin
					sent_tag_q <= EPOCH_CLEAR;
				end else if (cfg_we || (lookup.valid && lookup.start)) begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
				if (is_new && sent_s1) begin
					sent_tag_q <= epoch_s1;
				end
			end
		end
	end

endmodule

// File: rtl/dkmi_out_fifo.sv
// Small result queue that decouples the seen-set pipeline from output backpressure.
`timescale 1ns / 1ps
module dkmi_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dkmi_pkg::result_t             result,
	output logic [dkmi_pkg::FIFO_CNT_W-1:0] count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dkmi_pkg::IDX_W-1:0]    kmer_index
);
	import dkmi_pkg::*;

	logic [IDX_W-1:0]      entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign kmer_index = entry_q[rd_ptr_q];
	assign pop = out_valid && out_ready;
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (result.push) begin
			entry_q[wr_ptr_q] <= result.index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (result.push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({result.push, pop})
				2'b10: count_q <= count_q + FIFO_CNT_W'(1);
				2'b01: count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/dna_unique_kmer_indexer.sv
// Top level of the DNA k-mer indexer that emits each packed k-mer index once per sequence.
// The block takes one character per clock cycle while in_ready is high; in_ready is low
// during a clearing pass, while a restart waits for one, and while the result queue is
// nearly full. A result passes the seen-set stage register, then the result queue. The
// seen-set memory holds an 8-bit epoch tag for each of the 65536 k-mer codes. A new
// sequence or a write of kmer_size moves to the next epoch instead of clearing the memory.
// After reset, and again when the epochs run out after 254 restarts, a clearing pass writes
// all 65536 entries, one per cycle, accepting no character but taking writes of kmer_size.
`timescale 1ns / 1ps
module dna_unique_kmer_indexer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dkmi_pkg::K_W-1:0]   cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 base_char,
	input  logic                       seq_start,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dkmi_pkg::IDX_W-1:0] kmer_index
);
	import dkmi_pkg::*;

	lookup_t               lookup;
	result_t               result;
	logic                  lookup_ready;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic                  accept;

	assign in_ready = lookup_ready && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign accept = in_valid && in_ready;

	dkmi_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.base_char (base_char),
		.seq_start (seq_start),
		.lookup    (lookup)
	);

	dkmi_seen u_seen (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.in_valid     (in_valid),
		.seq_start    (seq_start),
		.lookup       (lookup),
		.lookup_ready (lookup_ready),
		.result       (result)
	);

	dkmi_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.result     (result),
		.count      (fifo_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kmer_index (kmer_index)
	);

endmodule

// File: dv/tb_dna_unique_kmer_indexer.sv
// Self-checking testbench for the DNA k-mer indexer with a queue-fed driver and a monitor.
`timescale 1ns / 1ps
module tb_dna_unique_kmer_indexer;
	import dkmi_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_PHASES = 11;
	localparam int STORM_PHASE = 7;
	localparam int STORM_CHARS = 260;
	localparam int PHASE_CHARS = 16;
	localparam logic [K_W-1:0] PHASE_K [NUM_PHASES] = '{
		4'd0, 4'd3, 4'd15, 4'd5, 4'd2, 4'd10, 4'd6, 4'd1, 4'd4, 4'd7, 4'd8
	};

	typedef struct {
		logic [7:0] ch;
		logic       start;
		logic       drain_first;
	} char_item_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [K_W-1:0]   cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       base_char = '0;
	logic             seq_start = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] kmer_index;

	char_item_t       char_q[$];
	logic [IDX_W-1:0] kmer_expect_q[$];
	bit               seen_index[int];
	logic [IDX_W-1:0] oldest_index;

	int unsigned kmer_size_reg = 8;
	int unsigned win_codes = 0;
	int unsigned win_bad = 0;
	int unsigned fill_cnt = 0;

	int chars_pushed = 0;
	int chars_taken = 0;
	int seqs_made = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;

	dna_unique_kmer_indexer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base_char(base_char),
		.seq_start(seq_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kmer_index(kmer_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_window();
		win_codes = 0;
		win_bad = 0;
		fill_cnt = 0;
		seen_index.delete();
	endfunction

	function automatic void set_kmer_size(input logic [K_W-1:0] value);
		kmer_size_reg = value;
		restart_window();
	endfunction

	// Shifts one character into the window and queues the index if it is new in this sequence.
	function automatic void predict_kmer_index(input logic [7:0] ch, input logic start);
		int unsigned code;
		int unsigned bad;
		int unsigned k;
		int unsigned idx;
		if (start)
			restart_window();
		code = 0;
		bad = 0;
		case (ch)
			CHAR_A_UC, CHAR_A_LC: code = CODE_A;
			CHAR_C_UC, CHAR_C_LC: code = CODE_C;
			CHAR_G_UC, CHAR_G_LC: code = CODE_G;
			CHAR_T_UC, CHAR_T_LC, CHAR_U_UC, CHAR_U_LC: code = CODE_T;
			default: bad = 1;
		endcase
		k = kmer_size_reg;
		if (k < 1)
			k = 1;
		if (k > MAX_K)
			k = MAX_K;
		win_codes = ((win_codes >> 2) | (code << (2 * (k - 1)))) & ((32'd1 << (2 * k)) - 1);
		win_bad = ((win_bad >> 1) | (bad << (k - 1))) & ((32'd1 << k) - 1);
		if (fill_cnt < k)
			fill_cnt++;
		if (fill_cnt < k)
			return;
		idx = (win_bad != 0) ? (32'd1 << (2 * k)) : win_codes;
		if (seen_index.exists(idx))
			return;
		seen_index[idx] = 1'b1;
		kmer_expect_q = {kmer_expect_q, idx[IDX_W-1:0]};
	endfunction

	function automatic logic [7:0] pick_char();
		logic [7:0] ch;
		if ($urandom_range(99) < 15) begin
			ch = 8'($urandom_range(255));
		end else begin
			case ($urandom_range(9))
				0: ch = CHAR_A_UC;
				1: ch = CHAR_C_UC;
				2: ch = CHAR_G_UC;
				3: ch = CHAR_T_UC;
				4: ch = CHAR_U_UC;
				5: ch = CHAR_A_LC;
				6: ch = CHAR_C_LC;
				7: ch = CHAR_G_LC;
				8: ch = CHAR_T_LC;
				default: ch = CHAR_U_LC;
			endcase
		end
		return ch;
	endfunction

	task automatic push_item(input logic [7:0] ch, input logic start, input logic drain);
		char_q = {char_q, char_item_t'{ch, start, drain}};
		chars_pushed++;
	endtask

	task automatic push_string(input string s, input logic start);
		int i;
		for (i = 0; i < s.len(); i++)
			push_item(s[i], start && (i == 0), 1'b0);
	endtask

	// Mostly short and medium sequences; some repeat a short motif so that indexes recur.
	task automatic gen_sequences(input int n);
		int left;
		int len;
		int sel;
		int motif_len;
		int i;
		logic [7:0] motif [3];
		logic [7:0] ch;
		left = n;
		while (left > 0) begin
			sel = $urandom_range(99);
			if (sel < 30)
				len = $urandom_range(3, 1);
			else if (sel < 85)
				len = $urandom_range(10, 4);
			else
				len = $urandom_range(24, 11);
			if (len > left)
				len = left;
			motif_len = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
			for (i = 0; i < 3; i++)
				motif[i] = pick_char();
			for (i = 0; i < len; i++) begin
				ch = (motif_len != 0) ? motif[i % motif_len] : pick_char();
				push_item(ch, i == 0,
					(i == 0) && (seqs_made == 3 || $urandom_range(19) == 0));
			end
			seqs_made++;
			left -= len;
		end
	endtask

	task automatic wait_drained();
		while (chars_taken != chars_pushed || kmer_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_kmer_size(input logic [K_W-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		set_kmer_size(value);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			base_char <= '0;
			seq_start <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_kmer_index(base_char, seq_start);
				chars_taken++;
			end
			if (!in_valid || in_ready) begin
				if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(char_q[0].drain_first && kmer_expect_q.size() != 0)) begin
					base_char <= char_q[0].ch;
					seq_start <= char_q[0].start;
					in_valid <= 1'b1;
					void'(char_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (kmer_expect_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("unexpected kmer_index %0d at %0t", kmer_index, $time);
				end else begin
					oldest_index = kmer_expect_q.pop_front();
					if (kmer_index !== oldest_index) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_REPORTS)
							$display("kmer_index mismatch: expected %0d, got %0d at %0t",
								oldest_index, kmer_index, $time);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int p;
		int i;
		send_idle_pct <= 9;
		recv_idle_pct <= 59;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Characters before any sequence start, both cases, U, and two invalid characters.
		push_string("ACGTacgU", 1'b0);
		push_string("u", 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'hFF, 1'b0, 1'b0);
		push_string("TTTTTTTTT", 1'b1);
		push_string("AC", 1'b1);
		wait_drained();
		write_kmer_size(4'd1);
		push_string("AaNn", 1'b1);

		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			if (p == 3) begin
				send_idle_pct <= 59;
				recv_idle_pct <= 9;
			end
			if (p == STORM_PHASE) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			write_kmer_size(PHASE_K[p]);
			if (p == STORM_PHASE) begin
				// One-character sequences use up the epoch tags and force a new clearing pass.
				hold_arm <= 1'b1;
				for (i = 0; i < STORM_CHARS; i++)
					push_item(pick_char(), 1'b1, 1'b0);
			end else begin
				gen_sequences(PHASE_CHARS);
			end
		end
		wait_drained();

		if (mismatch_cnt == 0 && kmer_expect_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/dkmi_pkg.sv
rtl/dkmi_window.sv
rtl/dkmi_seen.sv
rtl/dkmi_out_fifo.sv
rtl/dna_unique_kmer_indexer.sv
dv/tb_dna_unique_kmer_indexer.sv
